// File: sv/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg
// Shared types and constants of the keypad typematic event queue: beat
// structs, request and register codes, reset values and key masking.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int KEY_W       = 16;
  localparam int NUM_KEYS    = 16;
  localparam int QUEUE_DEPTH = 16;

  // Reset timing in ticks, scanned every SCAN_TICKS ticks
  localparam int TICK_HOLD   = 1000;
  localparam int TICK_REPEAT = 80;
  localparam int SCAN_TICKS  = 5;

  localparam logic [15:0] HOLD_RESET   = 16'(TICK_HOLD / SCAN_TICKS);
  localparam logic [15:0] REPEAT_RESET = 16'(TICK_REPEAT / SCAN_TICKS);
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // Keys at or above NUM_KEYS are ignored
  localparam logic [KEY_W-1:0] KEY_MASK =
    (NUM_KEYS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << NUM_KEYS) - 64'd1);

  // Request codes
  localparam logic [1:0] REQ_SCAN  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W  = 1;
  localparam logic [0:0] CFG_HOLD   = 1'b0;
  localparam logic [0:0] CFG_REPEAT = 1'b1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_bits;
  } req_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] event_keys;
    logic             event_pending;
    logic             dropped;
  } rsp_item_t;

  // Control carried alongside a pending event store read
  typedef struct packed {
    logic hit;
    logic pending;
    logic dropped;
  } stage_info_t;

endpackage

// File: sv/kte_event_ram.sv
// ----------------------------------------------------------------------------
// kte_event_ram
// Event store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kte_event_ram #(
  parameter int DEPTH = kte_pkg::QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [kte_pkg::KEY_W-1:0]  wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [kte_pkg::KEY_W-1:0]  rdata
);
  import kte_pkg::*;

  logic [KEY_W-1:0] store [DEPTH];

  // Write the pushed event
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // Read the oldest event; hold the data otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// File: sv/kte_ctrl.sv
// ----------------------------------------------------------------------------
// kte_ctrl
// Typematic timing, queue pointers and configuration registers. Issues the
// event store write for each queued event and the read for each hit read.
// ----------------------------------------------------------------------------
module kte_ctrl #(
  parameter int DEPTH = kte_pkg::QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  kte_pkg::req_item_t              req_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            stage_adv,
  output logic                            stage_valid,
  output kte_pkg::stage_info_t            stage_info,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [kte_pkg::KEY_W-1:0]       ram_wdata,
  output logic                            ram_re,
  output logic [AW-1:0]                   ram_raddr
);
  import kte_pkg::*;

  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

  logic [15:0]      hold_scans;
  logic [15:0]      repeat_scans;
  logic             held, held_next;
  logic             repeating, repeating_next;
  logic [15:0]      scan_count, scan_count_next;
  logic [AW-1:0]    read_ptr, read_ptr_next;
  logic [AW-1:0]    write_ptr, write_ptr_next;
  logic [FW-1:0]    fill_level, fill_level_next;
  logic             accept;
  logic [KEY_W-1:0] keys;
  logic [15:0]      count_inc;
  logic [15:0]      limit;
  logic             push;
  logic             full;
  logic             hit;
  logic             drop;

  assign cfg_ready = 1'b1;
  assign req_stall = stage_valid && !stage_adv;
  assign accept    = req_valid && !req_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_scans   <= HOLD_RESET;
      repeat_scans <= REPEAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOLD:   hold_scans   <= cfg_data;
        CFG_REPEAT: repeat_scans <= cfg_data;
        default:    hold_scans   <= hold_scans;
      endcase
    end
  end

  assign keys      = req_item.key_bits & KEY_MASK;
  assign count_inc = (scan_count == COUNT_MAX) ? scan_count : scan_count + 16'd1;
  assign limit     = repeating ? repeat_scans : hold_scans;
  assign full      = (fill_level == FILL_MAX);

  // Next state of the typematic timer and the queue
  always_comb begin
    held_next       = held;
    repeating_next  = repeating;
    scan_count_next = scan_count;
    read_ptr_next   = read_ptr;
    write_ptr_next  = write_ptr;
    fill_level_next = fill_level;
    push            = 1'b0;
    hit             = 1'b0;
    unique case (req_item.req_type)
      REQ_SCAN: begin
        if (!held) begin
          if (keys != '0) begin
            push            = 1'b1;
            held_next       = 1'b1;
            repeating_next  = 1'b0;
            scan_count_next = '0;
          end
        end else if (keys == '0) begin
          held_next       = 1'b0;
          repeating_next  = 1'b0;
          scan_count_next = '0;
        end else if (count_inc > limit) begin
          push            = 1'b1;
          repeating_next  = 1'b1;
          scan_count_next = '0;
        end else begin
          scan_count_next = count_inc;
        end
      end
      REQ_READ: begin
        if (fill_level != '0) begin
          hit             = 1'b1;
          read_ptr_next   = (read_ptr == PTR_LAST) ? '0 : read_ptr + AW'(1);
          fill_level_next = fill_level - FW'(1);
        end
      end
      REQ_CLEAR: begin
        read_ptr_next   = '0;
        write_ptr_next  = '0;
        fill_level_next = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    drop = push && full;
    if (push && !full) begin
      write_ptr_next  = (write_ptr == PTR_LAST) ? '0 : write_ptr + AW'(1);
      fill_level_next = fill_level + FW'(1);
    end
  end

  // Event store access for this beat
  assign ram_we    = accept && push && !full;
  assign ram_waddr = write_ptr;
  assign ram_wdata = keys;
  assign ram_re    = accept && hit;
  assign ram_raddr = read_ptr;

  // Advance state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 1'b0;
      repeating  <= 1'b0;
      scan_count <= '0;
      read_ptr   <= '0;
      write_ptr  <= '0;
      fill_level <= '0;
    end else if (accept) begin
      held       <= held_next;
      repeating  <= repeating_next;
      scan_count <= scan_count_next;
      read_ptr   <= read_ptr_next;
      write_ptr  <= write_ptr_next;
      fill_level <= fill_level_next;
    end
  end

  // Stage register waiting on the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (stage_adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_info.hit     <= hit;
      stage_info.pending <= (fill_level_next != '0);
      stage_info.dropped <= drop;
    end
  end

  // Write pointer sits fill_level entries past the read pointer
  logic [AW:0] wp_sum;
  logic [AW:0] wp_expect;
  assign wp_sum    = (AW + 1)'(read_ptr) + (AW + 1)'(fill_level);
  assign wp_expect = (wp_sum >= (AW + 1)'(DEPTH)) ? wp_sum - (AW + 1)'(DEPTH) : wp_sum;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_MAX)
    else $error("fill level beyond queue depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    (AW + 1)'(write_ptr) == wp_expect)
    else $error("write pointer out of step with read pointer and fill");

  a_drop_keeps_full: assert property (@(posedge clk) disable iff (rst)
    (accept && drop) |=> (fill_level == FILL_MAX))
    else $error("dropped event changed the fill level");

endmodule

// File: sv/kte_out_stage.sv
// ----------------------------------------------------------------------------
// kte_out_stage
// Response register: merges the event store read data with the stage
// control and holds the beat while the receiver stalls.
// ----------------------------------------------------------------------------
module kte_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       stage_valid,
  input  kte_pkg::stage_info_t       stage_info,
  input  logic [kte_pkg::KEY_W-1:0]  ram_rdata,
  output logic                       stage_adv,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output kte_pkg::rsp_item_t         rsp_item
);
  import kte_pkg::*;

  // Move the stage forward when the response register is free or drains
  assign stage_adv = stage_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      rsp_item.event_keys    <= stage_info.hit ? ram_rdata : '0;
      rsp_item.event_pending <= stage_info.pending;
      rsp_item.dropped       <= stage_info.dropped;
    end
  end

  a_drop_no_keys: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.dropped) |-> (rsp_item.event_keys == '0))
    else $error("dropped scan beat carries event keys");

endmodule

// File: sv/keypad_typematic_event_queue_core.sv
// ----------------------------------------------------------------------------
// keypad_typematic_event_queue_core
// Keypad auto-repeat with an event queue held in a synchronous memory.
// ----------------------------------------------------------------------------
// Takes one request beat per clock (scan, read or clear) while req_stall is
// low and returns one response beat for each via the stage and response
// registers. Counter and pointer updates finish in the accept cycle, so
// back-to-back requests see each other's effect and write and read of one
// entry never fall on the same edge. A response register lets one further
// request be taken while a response is stalled; beyond that, req_stall
// follows rsp_stall. No clearing pass after reset.
module keypad_typematic_event_queue_core #(
  parameter int QUEUE_DEPTH = kte_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  kte_pkg::req_item_t             req_item,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output kte_pkg::rsp_item_t             rsp_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import kte_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic             stage_valid;
  logic             stage_adv;
  stage_info_t      stage_info;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // Timer, pointers and registers
  kte_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_item    (req_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stage_adv   (stage_adv),
    .stage_valid (stage_valid),
    .stage_info  (stage_info),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  // Event store
  kte_event_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Response register
  kte_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_info  (stage_info),
    .ram_rdata   (ram_rdata),
    .stage_adv   (stage_adv),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_item    (rsp_item)
  );

  a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (stage_valid && rsp_valid && rsp_stall))
    else $error("request stalled with room in the pipeline");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_typematic_event_queue_core. A behavioural
// predictor of the typematic timing and the event queue runs alongside the
// block: directed beats cover idle requests, queue overflow and delays at the
// top of their range, and random key presses and reads run under several
// timings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kte_pkg::*;

  // Request code that the block leaves unused
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_item_t req_item;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: timing registers, typematic tracking and queued events
  logic [15:0] hold_scans_cfg;
  logic [15:0] repeat_scans_cfg;
  logic        keys_held;
  logic        repeat_phase;
  logic [15:0] scan_count;
  logic [15:0] key_events[$];

  rsp_item_t   rsp_expect_q[$];
  rsp_item_t   want;
  int          mismatch_count = 0;
  int          req_gap_max = 0;
  int          rsp_hold_max = 0;

  keypad_typematic_event_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle cycles for one beat; about a third of beats go without any
  function automatic int draw_wait(input int span);
    if ($urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, span);
  endfunction

  // Nonzero key mask: one key, every key or any mix
  function automatic logic [15:0] rand_keys();
    case ($urandom_range(0, 3))
      0: return 16'(1) << $urandom_range(0, 15);
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Queue one event; report whether it had to be dropped
  function automatic logic queue_event(input logic [15:0] keys);
    if (key_events.size() >= QUEUE_DEPTH)
      return 1'b1;
    key_events.push_back(keys);
    return 1'b0;
  endfunction

  // Advance the typematic state by one request and give its response
  function automatic rsp_item_t typematic_step(input req_item_t beat);
    rsp_item_t   rsp;
    logic [15:0] keys;
    logic [15:0] limit;
    rsp  = '0;
    keys = beat.key_bits & KEY_MASK;
    case (beat.req_type)
      REQ_SCAN: begin
        if (!keys_held) begin
          if (keys != '0) begin
            rsp.dropped  = queue_event(keys);
            keys_held    = 1'b1;
            repeat_phase = 1'b0;
            scan_count   = '0;
          end
        end else if (keys == '0) begin
          keys_held    = 1'b0;
          repeat_phase = 1'b0;
          scan_count   = '0;
        end else begin
          limit = repeat_phase ? repeat_scans_cfg : hold_scans_cfg;
          if (scan_count != COUNT_MAX)
            scan_count = scan_count + 16'd1;
          if (scan_count > limit) begin
            rsp.dropped  = queue_event(keys);
            repeat_phase = 1'b1;
            scan_count   = '0;
          end
        end
      end
      REQ_READ: begin
        if (key_events.size() != 0)
          rsp.event_keys = key_events.pop_front();
      end
      REQ_CLEAR: begin
        key_events.delete();
      end
      default: ;
    endcase
    rsp.event_pending = (key_events.size() != 0);
    return rsp;
  endfunction

  // Send one request beat; valid stays high when the next beat follows at once
  task automatic issue_request(input logic [1:0] kind, input logic [15:0] keys);
    req_item_t beat;
    int        gap;
    beat.req_type = kind;
    beat.key_bits = keys;
    gap = draw_wait(req_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= beat;
    do @(posedge clk); while (req_stall);
    rsp_expect_q.push_back(typematic_step(beat));
  endtask

  // Hold off requests until every response has come back
  task automatic wait_responses();
    req_valid <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk);
  endtask

  // Write both timing registers back to back
  task automatic set_timing(input logic [15:0] hold, input logic [15:0] rep);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HOLD;
    cfg_data  <= hold;
    do @(posedge clk); while (!cfg_ready);
    hold_scans_cfg = hold;
    cfg_index <= CFG_REPEAT;
    cfg_data  <= rep;
    do @(posedge clk); while (!cfg_ready);
    repeat_scans_cfg = rep;
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly key presses with reads mixed in, some stray beats
  task automatic run_random(input int n);
    int          done_items;
    int          span;
    int          press_len;
    logic [15:0] keys;
    done_items = 0;
    while (done_items < n) begin
      if ($urandom_range(0, 9) < 7) begin
        span = int'(hold_scans_cfg) + 3 * (int'(repeat_scans_cfg) + 1) + 4;
        if (span > 320)
          span = 320;
        press_len = $urandom_range(0, 1) ? span : $urandom_range(1, span);
        // Keep the press within the beats still to send
        if (press_len > n - done_items)
          press_len = n - done_items;
        keys = rand_keys();
        for (int i = 0; i < press_len; i++) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: issue_request(REQ_READ, 16'($urandom));
            4: begin
              keys = rand_keys();
              issue_request(REQ_SCAN, keys);
            end
            5: begin
              if ($urandom_range(0, 3) == 0)
                issue_request(REQ_CLEAR, 16'($urandom));
              else
                issue_request(REQ_SCAN, keys);
            end
            default: issue_request(REQ_SCAN, keys);
          endcase
        end
        done_items += press_len;
        if ($urandom_range(0, 4) != 0) begin
          issue_request(REQ_SCAN, '0);
          done_items++;
        end
      end else begin
        issue_request(2'($urandom_range(0, 3)), 16'($urandom));
        done_items++;
      end
    end
  endtask

  // Reads and clears on an empty queue, the unused code, a press and release
  task automatic test_idle_requests();
    req_gap_max  = 18;
    rsp_hold_max = 18;
    issue_request(REQ_READ, 16'hFFFF);
    issue_request(REQ_CLEAR, 16'h1234);
    issue_request(REQ_NONE, 16'hFFFF);
    issue_request(REQ_SCAN, 16'h0000);
    issue_request(REQ_SCAN, 16'hFFFF);
    issue_request(REQ_NONE, 16'h0000);
    issue_request(REQ_SCAN, 16'h8000);
    issue_request(REQ_READ, 16'h0000);
    issue_request(REQ_READ, 16'hFFFF);
    issue_request(REQ_SCAN, 16'h0000);
    issue_request(REQ_SCAN, 16'h0001);
    issue_request(REQ_CLEAR, 16'hFFFF);
    issue_request(REQ_READ, 16'h0000);
    wait_responses();
  endtask

  task automatic test_random_reset_timing();
    req_gap_max  = 18;
    rsp_hold_max = 18;
    run_random(280);
    wait_responses();
  endtask

  // Zero delays: every held scan queues an event until the queue overflows
  task automatic test_queue_overflow();
    req_gap_max  = 18;
    rsp_hold_max = 18;
    set_timing(16'd0, 16'd0);
    issue_request(REQ_CLEAR, 16'h0000);
    issue_request(REQ_SCAN, 16'h0000);
    issue_request(REQ_SCAN, 16'hAAAA);
    repeat (16) issue_request(REQ_SCAN, 16'hAAAA);
    issue_request(REQ_READ, 16'h0000);
    issue_request(REQ_SCAN, 16'hAAAA);
    issue_request(REQ_SCAN, 16'h0000);
    wait_responses();
  endtask

  // Delays at the top of their range: a long hold queues only the press,
  // then a short first delay fires once and the top repeat delay holds off
  task automatic test_high_limits();
    req_gap_max  = 0;
    rsp_hold_max = 0;
    set_timing(16'hFFFF, 16'hFFFF);
    issue_request(REQ_CLEAR, 16'h0000);
    issue_request(REQ_SCAN, 16'h0000);
    issue_request(REQ_SCAN, 16'h0001);
    repeat (24) issue_request(REQ_SCAN, 16'h0001);
    issue_request(REQ_READ, 16'h0000);
    issue_request(REQ_READ, 16'h0000);
    wait_responses();
    set_timing(16'd3, 16'hFFFF);
    issue_request(REQ_SCAN, 16'h0000);
    issue_request(REQ_SCAN, 16'h8000);
    repeat (12) issue_request(REQ_SCAN, 16'h8000);
    issue_request(REQ_SCAN, 16'h0000);
    wait_responses();
  endtask

  task automatic test_random_no_delay();
    req_gap_max  = 0;
    rsp_hold_max = 0;
    set_timing(16'd0, 16'd0);
    run_random(150);
    wait_responses();
  endtask

  task automatic test_random_short_delays();
    req_gap_max  = 18;
    rsp_hold_max = 0;
    set_timing(16'd5, 16'd2);
    run_random(200);
    wait_responses();
  endtask

  task automatic test_random_mixed_timing();
    req_gap_max  = 18;
    rsp_hold_max = 18;
    set_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 10)));
    run_random(150);
    wait_responses();
  endtask

  // First repeat at once, then a repeat limit that is never exceeded
  task automatic test_random_single_repeat();
    req_gap_max  = 0;
    rsp_hold_max = 18;
    set_timing(16'd0, 16'hFFFF);
    run_random(100);
    wait_responses();
  endtask

  // Response side: stall for a drawn number of cycles, then take one beat
  initial begin : rsp_sink
    int hold;
    rsp_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = draw_wait(rsp_hold_max);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  // Compare each accepted response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expect_q.size() == 0) begin
        $error("response beat with nothing expected: %h", rsp_item);
        mismatch_count++;
      end else begin
        want = rsp_expect_q.pop_front();
        if (rsp_item.event_keys !== want.event_keys) begin
          $error("event_keys: expected %h, got %h", want.event_keys, rsp_item.event_keys);
          mismatch_count++;
        end
        if (rsp_item.event_pending !== want.event_pending) begin
          $error("event_pending: expected %b, got %b",
                 want.event_pending, rsp_item.event_pending);
          mismatch_count++;
        end
        if (rsp_item.dropped !== want.dropped) begin
          $error("dropped: expected %b, got %b", want.dropped, rsp_item.dropped);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_item  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_scans_cfg   = HOLD_RESET;
    repeat_scans_cfg = REPEAT_RESET;
    keys_held    = 1'b0;
    repeat_phase = 1'b0;
    scan_count   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_random_reset_timing();
    test_queue_overflow();
    test_high_limits();
    test_random_no_delay();
    test_random_short_delays();
    test_random_mixed_timing();
    test_random_single_repeat();

    // Let any stray beat show before the verdict
    repeat (8) @(posedge clk);
    if (rsp_expect_q.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Drop out if the run hangs
  initial begin
    #(4ms);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
